### rtl/shm_pkg.sv
// Package with the shared types and constants of the shredder motor sequencer.
package shm_pkg;

    localparam int unsigned CountWidth  = 8;
    localparam int unsigned TorqueWidth = 12;
    localparam int unsigned ModeWidth   = 4;
    localparam int unsigned CmdWidth    = 3;
    localparam int unsigned CfgIdxWidth = 3;
    localparam int unsigned CfgDatWidth = 12;
    localparam int unsigned DriveWidth  = 5;

    // Consecutive high interlock ticks tolerated before a trip.
    localparam logic [1:0] InterlockHighs = 2'd3;

    // Bit positions inside the drive level vector.
    localparam int unsigned DrvFeeder = 0;
    localparam int unsigned DrvPicker = 1;
    localparam int unsigned DrvCw     = 2;
    localparam int unsigned DrvCcw    = 3;
    localparam int unsigned DrvRspeed = 4;

    // Bit positions inside mode_bits.
    localparam int unsigned ModeFeederInterval = 0;
    localparam int unsigned ModePickerInterval = 1;
    localparam int unsigned ModeAutoReverse    = 2;
    localparam int unsigned ModeShredderCcw    = 3;

    typedef enum logic [CmdWidth-1:0] {
        CMD_TICK          = 3'd0,
        CMD_FEEDER_START  = 3'd1,
        CMD_FEEDER_STOP   = 3'd2,
        CMD_PICKER_START  = 3'd3,
        CMD_PICKER_STOP   = 3'd4,
        CMD_SHRED_START   = 3'd5,
        CMD_SHRED_STOP    = 3'd6
    } t_cmd;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_FEEDER_RUN   = 3'd0,
        CFG_FEEDER_STOP  = 3'd1,
        CFG_PICKER_RUN   = 3'd2,
        CFG_PICKER_STOP  = 3'd3,
        CFG_REVERSE      = 3'd4,
        CFG_REVERSE_WAIT = 3'd5,
        CFG_TORQUE_LIMIT = 3'd6,
        CFG_MODE         = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [CmdWidth-1:0]    command;
        logic                   interlock_level;
        logic [TorqueWidth-1:0] torque_sample;
    } t_in_item;

    typedef struct packed {
        logic feeder_on;
        logic picker_on;
        logic shredder_cw;
        logic shredder_ccw;
        logic reverse_speed;
        logic heartbeat;
        logic interlock_trip;
        logic reverse_pending;
    } t_out_item;

    typedef struct packed {
        logic [CountWidth-1:0]  feeder_run_ticks;
        logic [CountWidth-1:0]  feeder_stop_ticks;
        logic [CountWidth-1:0]  picker_run_ticks;
        logic [CountWidth-1:0]  picker_stop_ticks;
        logic [CountWidth-1:0]  reverse_ticks;
        logic [CountWidth-1:0]  reverse_wait_ticks;
        logic [TorqueWidth-1:0] torque_limit;
        logic [ModeWidth-1:0]   mode_bits;
    } t_cfg;

    typedef struct packed {
        logic                  feeder_started;
        logic                  feeder_phase_on;
        logic [CountWidth-1:0] feeder_count;
        logic                  picker_started;
        logic                  picker_phase_on;
        logic [CountWidth-1:0] picker_count;
        logic                  reverse_waiting;
        logic                  reverse_active;
        logic [CountWidth-1:0] reverse_count;
        logic [1:0]            interlock_count;
        logic [DriveWidth-1:0] drive_levels;
        logic                  heartbeat_level;
    } t_state;

    // State after reset: everything cleared, heartbeat high.
    localparam t_state StateReset = '{heartbeat_level: 1'b1, default: '0};

endpackage

### rtl/shm_cfg_regs.sv
// Configuration register file of the shredder motor sequencer.
module shm_cfg_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_wr_en,
    input  logic [shm_pkg::CfgIdxWidth-1:0] i_wr_index,
    input  logic [shm_pkg::CfgDatWidth-1:0] i_wr_data,
    output shm_pkg::t_cfg             o_cfg
);
    import shm_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.feeder_run_ticks   <= 8'd10;
            r_cfg.feeder_stop_ticks  <= 8'd10;
            r_cfg.picker_run_ticks   <= 8'd10;
            r_cfg.picker_stop_ticks  <= 8'd10;
            r_cfg.reverse_ticks      <= 8'd30;
            r_cfg.reverse_wait_ticks <= 8'd20;
            r_cfg.torque_limit       <= 12'd3276;
            r_cfg.mode_bits          <= 4'd0;
        end else if (i_wr_en) begin
            unique case (t_cfg_idx'(i_wr_index))
                CFG_FEEDER_RUN:   r_cfg.feeder_run_ticks   <= i_wr_data[CountWidth-1:0];
                CFG_FEEDER_STOP:  r_cfg.feeder_stop_ticks  <= i_wr_data[CountWidth-1:0];
                CFG_PICKER_RUN:   r_cfg.picker_run_ticks   <= i_wr_data[CountWidth-1:0];
                CFG_PICKER_STOP:  r_cfg.picker_stop_ticks  <= i_wr_data[CountWidth-1:0];
                CFG_REVERSE:      r_cfg.reverse_ticks      <= i_wr_data[CountWidth-1:0];
                CFG_REVERSE_WAIT: r_cfg.reverse_wait_ticks <= i_wr_data[CountWidth-1:0];
                CFG_TORQUE_LIMIT: r_cfg.torque_limit       <= i_wr_data[TorqueWidth-1:0];
                CFG_MODE:         r_cfg.mode_bits          <= i_wr_data[ModeWidth-1:0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/shm_core.sv
// Sequencer state registers and the single-pass update logic for one item.
module shm_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_update,
    input  shm_pkg::t_in_item  i_item,
    input  shm_pkg::t_cfg      i_cfg,
    output shm_pkg::t_out_item o_result
);
    import shm_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   trip;

    always_comb begin
        n_state = r_state;
        trip    = 1'b0;
        unique case (i_item.command)
            CMD_TICK: begin
                // Feeder interval phase.
                if (n_state.feeder_started && i_cfg.mode_bits[ModeFeederInterval]) begin
                    if (n_state.feeder_count < (n_state.feeder_phase_on ?
                            i_cfg.feeder_run_ticks : i_cfg.feeder_stop_ticks)) begin
                        n_state.feeder_count = n_state.feeder_count + 8'd1;
                    end else begin
                        n_state.feeder_count = '0;
                        n_state.feeder_phase_on = !n_state.feeder_phase_on;
                        n_state.drive_levels[DrvFeeder] = n_state.feeder_phase_on;
                    end
                end
                // Picker interval phase.
                if (n_state.picker_started && i_cfg.mode_bits[ModePickerInterval]) begin
                    if (n_state.picker_count < (n_state.picker_phase_on ?
                            i_cfg.picker_run_ticks : i_cfg.picker_stop_ticks)) begin
                        n_state.picker_count = n_state.picker_count + 8'd1;
                    end else begin
                        n_state.picker_count = '0;
                        n_state.picker_phase_on = !n_state.picker_phase_on;
                        n_state.drive_levels[DrvPicker] = n_state.picker_phase_on;
                    end
                end
                // The wait and the reverse drive share one counter; a wait that
                // ends starts the drive, which already counts on this tick.
                if (n_state.reverse_waiting) begin
                    if (n_state.reverse_count < i_cfg.reverse_wait_ticks) begin
                        n_state.reverse_count = n_state.reverse_count + 8'd1;
                    end else begin
                        n_state.drive_levels[DrvRspeed] = 1'b1;
                        n_state.drive_levels[DrvCw]     = 1'b1;
                        n_state.reverse_count   = '0;
                        n_state.reverse_waiting = 1'b0;
                        n_state.reverse_active  = 1'b1;
                    end
                end
                if (n_state.reverse_active) begin
                    if (n_state.reverse_count < i_cfg.reverse_ticks) begin
                        n_state.reverse_count = n_state.reverse_count + 8'd1;
                    end else begin
                        n_state.reverse_count = '0;
                        n_state.drive_levels[DrvCw]     = 1'b0;
                        n_state.drive_levels[DrvRspeed] = 1'b0;
                        n_state.reverse_active = 1'b0;
                    end
                end
                // Interlock debounce.
                if (!i_item.interlock_level) begin
                    n_state.interlock_count = '0;
                end else if (n_state.interlock_count < InterlockHighs) begin
                    n_state.interlock_count = n_state.interlock_count + 2'd1;
                end else begin
                    n_state.drive_levels[DrvCw]     = 1'b0;
                    n_state.drive_levels[DrvCcw]    = 1'b0;
                    n_state.drive_levels[DrvFeeder] = 1'b0;
                    n_state.drive_levels[DrvPicker] = 1'b0;
                    n_state.reverse_waiting = 1'b0;
                    n_state.feeder_started  = 1'b0;
                    n_state.picker_started  = 1'b0;
                    n_state.interlock_count = '0;
                    trip = 1'b1;
                end
                n_state.heartbeat_level = !n_state.heartbeat_level;
                // Overload check comes last.
                if (i_cfg.mode_bits[ModeAutoReverse] &&
                        (i_item.torque_sample > i_cfg.torque_limit)) begin
                    n_state.drive_levels[DrvCw]     = 1'b0;
                    n_state.drive_levels[DrvCcw]    = 1'b0;
                    n_state.drive_levels[DrvFeeder] = 1'b0;
                    n_state.drive_levels[DrvPicker] = 1'b0;
                    n_state.reverse_waiting = 1'b1;
                end
            end
            CMD_FEEDER_START: begin
                n_state.drive_levels[DrvFeeder] = 1'b1;
                n_state.feeder_started  = 1'b1;
                n_state.feeder_phase_on = 1'b1;
                n_state.feeder_count    = '0;
            end
            CMD_FEEDER_STOP: begin
                n_state.drive_levels[DrvFeeder] = 1'b0;
                n_state.feeder_started = 1'b0;
                n_state.feeder_count   = '0;
            end
            CMD_PICKER_START: begin
                n_state.drive_levels[DrvPicker] = 1'b1;
                n_state.picker_started  = 1'b1;
                n_state.picker_phase_on = 1'b1;
                n_state.picker_count    = '0;
            end
            CMD_PICKER_STOP: begin
                n_state.drive_levels[DrvPicker] = 1'b0;
                n_state.picker_started = 1'b0;
                n_state.picker_count   = '0;
            end
            CMD_SHRED_START: begin
                n_state.drive_levels[DrvCcw] = i_cfg.mode_bits[ModeShredderCcw];
                n_state.drive_levels[DrvCw]  = !i_cfg.mode_bits[ModeShredderCcw];
            end
            CMD_SHRED_STOP: begin
                n_state.drive_levels[DrvCw]  = 1'b0;
                n_state.drive_levels[DrvCcw] = 1'b0;
            end
            default: begin
                // The unused command code leaves everything as it is.
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StateReset;
        end else if (i_update) begin
            r_state <= n_state;
        end
    end

    assign o_result.feeder_on       = n_state.drive_levels[DrvFeeder];
    assign o_result.picker_on       = n_state.drive_levels[DrvPicker];
    assign o_result.shredder_cw     = n_state.drive_levels[DrvCw];
    assign o_result.shredder_ccw    = n_state.drive_levels[DrvCcw];
    assign o_result.reverse_speed   = n_state.drive_levels[DrvRspeed];
    assign o_result.heartbeat       = n_state.heartbeat_level;
    assign o_result.interlock_trip  = trip;
    assign o_result.reverse_pending = n_state.reverse_waiting;

endmodule

### rtl/shredder_motor_sequencer.sv
// Top level of the shredder motor sequencer: input stage, core and result stage.
//
//  Channel   Direction  Handshake                   Payload
//  -------   ---------  --------------------------  ----------------------------
//  in        sink       i_in_valid / o_in_ready     i_in_item  (t_in_item)
//  out       source     o_out_valid / i_out_ready   o_out_item (t_out_item)
//  cfg       sink       i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// An item's result passes the input register and then the core update logic into
// the result register, from which it transfers; a stalled output holds it there.
// The core state advances when an item moves from the input register to the
// result register, so one item per cycle is sustained while the output side
// keeps taking results.
// Reset (synchronous, active low) empties both stages, loads the register
// defaults and returns the sequencer state to all drives off, heartbeat high.
// When the output stalls, a held result keeps the input register occupied;
// the input channel still takes one transfer into a free input register.
// The configuration port takes a write in every cycle.
module shredder_motor_sequencer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  shm_pkg::t_in_item              i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output shm_pkg::t_out_item             o_out_item,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [shm_pkg::CfgIdxWidth-1:0] i_cfg_index,
    input  logic [shm_pkg::CfgDatWidth-1:0] i_cfg_data
);
    import shm_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    t_cfg      cfg;
    t_out_item core_result;
    logic      out_free;
    logic      advance;

    // The result register is free when empty or when its result transfers now.
    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    shm_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    shm_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (advance),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    // Valid flags of both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
        if (advance) begin
            r_out_item <= core_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

### rtl/shm_checker.sv
// Port-level checker of the shredder motor sequencer and its bind statement.
module shm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input shm_pkg::t_out_item o_out_item
);
    import shm_pkg::*;

    // Reset empties the result stage.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A stalled result holds its value.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // With no result waiting, the pipeline always takes a new item.
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty output");

    // An interlock trip leaves every motor drive off.
    a_trip_drives_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.interlock_trip |->
            !o_out_item.feeder_on && !o_out_item.picker_on &&
            !o_out_item.shredder_cw && !o_out_item.shredder_ccw)
        else $error("drive on after interlock trip");

endmodule

bind shredder_motor_sequencer shm_checker u_shm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

### tb/sv/shredder_motor_sequencer_tb.sv
// Self-checking testbench for the shredder motor sequencer: random and directed items.
module shredder_motor_sequencer_tb;
    import shm_pkg::*;

    // Cycles without any transfer on any channel before the run is declared hung.
    localparam int StallLimit = 2000;
    // Command code outside the defined set; the block must treat it as a no-op.
    localparam logic [CmdWidth-1:0] CmdUnused = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                   item_valid = 1'b0;
    t_in_item               item_data = '0;
    logic                   result_ready = 1'b0;
    logic                   reg_wr_valid = 1'b0;
    logic [CfgIdxWidth-1:0] reg_wr_index = '0;
    logic [CfgDatWidth-1:0] reg_wr_data = '0;

    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_item;
    logic      o_cfg_ready;

    // Items waiting for the driver, and the outputs the sequencer owes us.
    t_in_item  pending_items[$];
    t_out_item expected_results[$];
    int        results_owed = 0;

    // The testbench's own view of the register file and sequencer state.
    t_cfg   reg_file;
    t_state seq_state;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int high_run_left = 0;
    int mismatches = 0;
    int idle_cycles = 0;

    shredder_motor_sequencer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (item_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (item_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (result_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (reg_wr_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (reg_wr_index),
        .i_cfg_data  (reg_wr_data)
    );

    always #4 i_clk = ~i_clk;

    // One run/stop interval counter step; flips the phase and its drive bit at the limit.
    task automatic advance_interval(inout logic phase_on, inout logic [CountWidth-1:0] count,
                                    input logic [CountWidth-1:0] run_ticks,
                                    input logic [CountWidth-1:0] stop_ticks,
                                    input int unsigned drive_bit);
        logic [CountWidth-1:0] limit;
        limit = phase_on ? run_ticks : stop_ticks;
        if (count < limit) begin
            count = count + 8'd1;
        end else begin
            count = '0;
            phase_on = !phase_on;
            seq_state.drive_levels[drive_bit] = phase_on;
        end
    endtask

    // Interlock trip and overload both drop the four motor drives but keep the speed select.
    task automatic halt_motors();
        seq_state.drive_levels[DrvFeeder] = 1'b0;
        seq_state.drive_levels[DrvPicker] = 1'b0;
        seq_state.drive_levels[DrvCw]     = 1'b0;
        seq_state.drive_levels[DrvCcw]    = 1'b0;
    endtask

    // Applies one accepted item to the predicted state and queues the output it must produce.
    task automatic advance_sequencer(input t_in_item item);
        t_out_item res;
        logic      trip;
        trip = 1'b0;
        case (item.command)
            CMD_TICK: begin
                if (seq_state.feeder_started && reg_file.mode_bits[ModeFeederInterval])
                    advance_interval(seq_state.feeder_phase_on, seq_state.feeder_count,
                                     reg_file.feeder_run_ticks, reg_file.feeder_stop_ticks,
                                     DrvFeeder);
                if (seq_state.picker_started && reg_file.mode_bits[ModePickerInterval])
                    advance_interval(seq_state.picker_phase_on, seq_state.picker_count,
                                     reg_file.picker_run_ticks, reg_file.picker_stop_ticks,
                                     DrvPicker);
                // The wait and the reverse drive share one counter; a wait that ends
                // hands over to the drive, which already counts on this same tick.
                if (seq_state.reverse_waiting) begin
                    if (seq_state.reverse_count < reg_file.reverse_wait_ticks) begin
                        seq_state.reverse_count = seq_state.reverse_count + 8'd1;
                    end else begin
                        seq_state.drive_levels[DrvCw]     = 1'b1;
                        seq_state.drive_levels[DrvRspeed] = 1'b1;
                        seq_state.reverse_count   = '0;
                        seq_state.reverse_waiting = 1'b0;
                        seq_state.reverse_active  = 1'b1;
                    end
                end
                if (seq_state.reverse_active) begin
                    if (seq_state.reverse_count < reg_file.reverse_ticks) begin
                        seq_state.reverse_count = seq_state.reverse_count + 8'd1;
                    end else begin
                        seq_state.reverse_count = '0;
                        seq_state.drive_levels[DrvCw]     = 1'b0;
                        seq_state.drive_levels[DrvRspeed] = 1'b0;
                        seq_state.reverse_active = 1'b0;
                    end
                end
                // A high level after three high ticks in a row trips; an active reverse keeps
                // counting with its speed select on, but its clockwise drive goes off.
                if (!item.interlock_level) begin
                    seq_state.interlock_count = '0;
                end else if (seq_state.interlock_count < InterlockHighs) begin
                    seq_state.interlock_count = seq_state.interlock_count + 2'd1;
                end else begin
                    halt_motors();
                    seq_state.reverse_waiting = 1'b0;
                    seq_state.feeder_started  = 1'b0;
                    seq_state.picker_started  = 1'b0;
                    seq_state.interlock_count = '0;
                    trip = 1'b1;
                end
                seq_state.heartbeat_level = !seq_state.heartbeat_level;
                if (reg_file.mode_bits[ModeAutoReverse] &&
                    item.torque_sample > reg_file.torque_limit) begin
                    halt_motors();
                    seq_state.reverse_waiting = 1'b1;
                end
            end
            CMD_FEEDER_START: begin
                seq_state.drive_levels[DrvFeeder] = 1'b1;
                seq_state.feeder_started  = 1'b1;
                seq_state.feeder_phase_on = 1'b1;
                seq_state.feeder_count    = '0;
            end
            CMD_FEEDER_STOP: begin
                seq_state.drive_levels[DrvFeeder] = 1'b0;
                seq_state.feeder_started = 1'b0;
                seq_state.feeder_count   = '0;
            end
            CMD_PICKER_START: begin
                seq_state.drive_levels[DrvPicker] = 1'b1;
                seq_state.picker_started  = 1'b1;
                seq_state.picker_phase_on = 1'b1;
                seq_state.picker_count    = '0;
            end
            CMD_PICKER_STOP: begin
                seq_state.drive_levels[DrvPicker] = 1'b0;
                seq_state.picker_started = 1'b0;
                seq_state.picker_count   = '0;
            end
            CMD_SHRED_START: begin
                seq_state.drive_levels[DrvCw]  = !reg_file.mode_bits[ModeShredderCcw];
                seq_state.drive_levels[DrvCcw] = reg_file.mode_bits[ModeShredderCcw];
            end
            CMD_SHRED_STOP: begin
                seq_state.drive_levels[DrvCw]  = 1'b0;
                seq_state.drive_levels[DrvCcw] = 1'b0;
            end
            default: begin
                // The unused code leaves everything as it is.
            end
        endcase
        res.feeder_on       = seq_state.drive_levels[DrvFeeder];
        res.picker_on       = seq_state.drive_levels[DrvPicker];
        res.shredder_cw     = seq_state.drive_levels[DrvCw];
        res.shredder_ccw    = seq_state.drive_levels[DrvCcw];
        res.reverse_speed   = seq_state.drive_levels[DrvRspeed];
        res.heartbeat       = seq_state.heartbeat_level;
        res.interlock_trip  = trip;
        res.reverse_pending = seq_state.reverse_waiting;
        expected_results.push_back(res);
    endtask

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task automatic check_field(input string name, input logic want, input logic got);
        if (got !== want)
            flag_mismatch($sformatf("%s expected %0b actual %0b", name, want, got));
    endtask

    // Driver: presents queued items and predicts each one as its transfer happens.
    always @(posedge i_clk) begin : item_driver
        logic take;
        take = item_valid && o_in_ready;
        if (!i_rst_n) begin
            item_valid <= 1'b0;
        end else begin
            if (take)
                advance_sequencer(item_data);
            if (!item_valid || take) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    item_data  <= pending_items.pop_front();
                    item_valid <= 1'b1;
                end else begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares every result transfer against the oldest prediction.
    always @(posedge i_clk) begin : result_monitor
        t_out_item want;
        if (!i_rst_n) begin
            result_ready <= 1'b0;
        end else begin
            if (o_out_valid && result_ready) begin
                if (expected_results.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result %h", o_out_item));
                end else begin
                    want = expected_results.pop_front();
                    results_owed--;
                    check_field("feeder_on", want.feeder_on, o_out_item.feeder_on);
                    check_field("picker_on", want.picker_on, o_out_item.picker_on);
                    check_field("shredder_cw", want.shredder_cw, o_out_item.shredder_cw);
                    check_field("shredder_ccw", want.shredder_ccw, o_out_item.shredder_ccw);
                    check_field("reverse_speed", want.reverse_speed, o_out_item.reverse_speed);
                    check_field("heartbeat", want.heartbeat, o_out_item.heartbeat);
                    check_field("interlock_trip", want.interlock_trip,
                                o_out_item.interlock_trip);
                    check_field("reverse_pending", want.reverse_pending,
                                o_out_item.reverse_pending);
                end
            end
            result_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: any transfer on any channel counts as progress.
    always @(posedge i_clk) begin : stall_watchdog
        if ((item_valid && o_in_ready) || (o_out_valid && result_ready) ||
            (reg_wr_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= StallLimit) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // One register write; unused upper data bits carry noise the block must ignore.
    task automatic write_register(input t_cfg_idx idx, input logic [CfgDatWidth-1:0] value);
        logic [CfgDatWidth-1:0] wdata;
        wdata = value;
        if (idx == CFG_MODE)
            wdata[CfgDatWidth-1:ModeWidth] = (CfgDatWidth-ModeWidth)'($urandom());
        else if (idx != CFG_TORQUE_LIMIT)
            wdata[CfgDatWidth-1:CountWidth] = (CfgDatWidth-CountWidth)'($urandom());
        @(posedge i_clk);
        reg_wr_valid <= 1'b1;
        reg_wr_index <= idx;
        reg_wr_data  <= wdata;
        do @(posedge i_clk); while (!o_cfg_ready);
        reg_wr_valid <= 1'b0;
        case (idx)
            CFG_FEEDER_RUN:   reg_file.feeder_run_ticks   = value[CountWidth-1:0];
            CFG_FEEDER_STOP:  reg_file.feeder_stop_ticks  = value[CountWidth-1:0];
            CFG_PICKER_RUN:   reg_file.picker_run_ticks   = value[CountWidth-1:0];
            CFG_PICKER_STOP:  reg_file.picker_stop_ticks  = value[CountWidth-1:0];
            CFG_REVERSE:      reg_file.reverse_ticks      = value[CountWidth-1:0];
            CFG_REVERSE_WAIT: reg_file.reverse_wait_ticks = value[CountWidth-1:0];
            CFG_TORQUE_LIMIT: reg_file.torque_limit       = value[TorqueWidth-1:0];
            CFG_MODE:         reg_file.mode_bits          = value[ModeWidth-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [7:0] feeder_run, input logic [7:0] feeder_stop,
                                  input logic [7:0] picker_run, input logic [7:0] picker_stop,
                                  input logic [7:0] rev_ticks, input logic [7:0] rev_wait,
                                  input logic [11:0] limit, input logic [3:0] mode);
        write_register(CFG_FEEDER_RUN, 12'(feeder_run));
        write_register(CFG_FEEDER_STOP, 12'(feeder_stop));
        write_register(CFG_PICKER_RUN, 12'(picker_run));
        write_register(CFG_PICKER_STOP, 12'(picker_stop));
        write_register(CFG_REVERSE, 12'(rev_ticks));
        write_register(CFG_REVERSE_WAIT, 12'(rev_wait));
        write_register(CFG_TORQUE_LIMIT, limit);
        write_register(CFG_MODE, 12'(mode));
    endtask

    task automatic queue_item(input logic [CmdWidth-1:0] cmd, input logic level,
                              input logic [TorqueWidth-1:0] torque);
        t_in_item item;
        item.command         = cmd;
        item.interlock_level = level;
        item.torque_sample   = torque;
        pending_items.push_back(item);
        results_owed++;
    endtask

    // Mostly ticks, with interlock bursts, some long enough to trip, and occasional overloads,
    // so the interval, reverse and interlock sequences all get exercised.
    task automatic queue_random_items(input int count);
        logic [CmdWidth-1:0]    cmd;
        logic                   level;
        logic [TorqueWidth-1:0] torque;
        repeat (count) begin
            if ($urandom_range(99) < 60)
                cmd = CMD_TICK;
            else
                cmd = CmdWidth'($urandom_range(7, 1));
            if (high_run_left == 0 && $urandom_range(99) < 4)
                high_run_left = int'($urandom_range(6, 1));
            if (high_run_left != 0) begin
                level = 1'b1;
                high_run_left--;
            end else begin
                level = ($urandom_range(99) < 3);
            end
            if ($urandom_range(99) < 4)
                torque = TorqueWidth'($urandom_range(4095));
            else
                torque = TorqueWidth'($urandom_range(reg_file.torque_limit));
            queue_item(cmd, level, torque);
        end
    endtask

    // The block is idle once every queued item has produced its result.
    task automatic wait_drained();
        while (results_owed != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int count);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        queue_random_items(count);
        wait_drained();
    endtask

    initial begin
        reg_file.feeder_run_ticks   = 8'd10;
        reg_file.feeder_stop_ticks  = 8'd10;
        reg_file.picker_run_ticks   = 8'd10;
        reg_file.picker_stop_ticks  = 8'd10;
        reg_file.reverse_ticks      = 8'd30;
        reg_file.reverse_wait_ticks = 8'd20;
        reg_file.torque_limit       = 12'd3276;
        reg_file.mode_bits          = 4'd0;
        seq_state = '0;
        seq_state.heartbeat_level = 1'b1;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: every command, field extremes, a trip during an active
        // reverse drive and a second trip after a later overload reverse has ended.
        send_idle_pct = 7;
        recv_idle_pct = 67;
        apply_settings(8'd1, 8'd0, 8'd2, 8'd1, 8'd1, 8'd2, 12'd2048, 4'b1111);
        queue_item(CmdUnused, 1'b1, 12'd4095);
        queue_item(CMD_FEEDER_START, 1'b0, 12'd0);
        queue_item(CMD_PICKER_START, 1'b0, 12'd0);
        queue_item(CMD_SHRED_START, 1'b0, 12'd0);
        queue_item(CMD_TICK, 1'b0, 12'd0);
        queue_item(CMD_TICK, 1'b0, 12'd2048);
        queue_item(CMD_TICK, 1'b1, 12'd2049);
        queue_item(CMD_TICK, 1'b1, 12'd0);
        queue_item(CMD_TICK, 1'b1, 12'd0);
        queue_item(CMD_TICK, 1'b1, 12'd0);
        queue_item(CMD_TICK, 1'b0, 12'd0);
        queue_item(CMD_SHRED_START, 1'b0, 12'd0);
        queue_item(CMD_FEEDER_START, 1'b0, 12'd0);
        queue_item(CMD_TICK, 1'b0, 12'd4095);
        queue_item(CMD_TICK, 1'b1, 12'd0);
        queue_item(CMD_TICK, 1'b1, 12'd0);
        queue_item(CMD_TICK, 1'b1, 12'd0);
        queue_item(CMD_TICK, 1'b1, 12'd0);
        queue_item(CMD_SHRED_STOP, 1'b0, 12'd0);
        queue_item(CMD_FEEDER_STOP, 1'b0, 12'd0);
        queue_item(CMD_PICKER_STOP, 1'b0, 12'd0);
        queue_item(CMD_TICK, 1'b0, 12'd0);
        wait_drained();

        // Random part: the receiver stalls first, then the sender, then neither.
        apply_settings(8'd3, 8'd2, 8'd1, 8'd4, 8'd5, 8'd3, 12'd2000, 4'b0111);
        run_phase(7, 67, 260);
        apply_settings(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 12'd0, 4'b1111);
        run_phase(7, 67, 260);
        apply_settings(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 12'd4095, 4'b1011);
        run_phase(67, 7, 260);
        apply_settings(8'd6, 8'd1, 8'd2, 8'd7, 8'd3, 8'd8, 12'd3500, 4'b0100);
        run_phase(67, 7, 260);
        apply_settings(8'($urandom_range(7)), 8'($urandom_range(7)), 8'($urandom_range(7)),
                       8'($urandom_range(7)), 8'($urandom_range(7)), 8'($urandom_range(7)),
                       12'($urandom_range(3800, 1500)), 4'($urandom_range(15)));
        run_phase(0, 0, 260);
        apply_settings(8'd1, 8'd3, 8'd9, 8'd0, 8'd12, 8'd2, 12'd3000, 4'b1111);
        run_phase(0, 0, 280);

        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
